### rtl/core/slen_pkg.sv
`default_nettype none

package slen_pkg;

	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned POS_W    = 10;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LEN_W    = 11;

	// Request codes; code seven is unused and is answered with an OK status.
	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 3'd0,
		FN_INSERT = 3'd1,
		FN_ERASE  = 3'd2,
		FN_FIND   = 3'd3,
		FN_READ   = 3'd4,
		FN_WRITE  = 3'd5,
		FN_CLEAR  = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} state_t;

endpackage

`default_nettype wire

### rtl/core/sequential_list_engine_unit.sv
`default_nettype none

// Ordered list of signed 32-bit elements held in one synchronous RAM of CAPACITY
// entries, with the current length kept in a register.
// A request transaction is taken on a rising edge where start is high and busy is
// low; func, position and value are sampled then. Exactly one result transaction
// follows: done is high for a single cycle while status, read_value, found_index
// and length carry the answer. The receiver cannot stall, so nothing waits on it.
// Append, write, clear, rejected requests and the unused code finish in the execute
// state; reads, inserts, erases and finds go on into the walk state. An insert moves
// the elements from the end down to the position one place up and then writes the
// new value; an erase moves the elements after the position one place down; a find
// compares from index 0 and stops at the first match or at the end of the list.
// Every element that is moved or compared takes its turn on the single RAM read
// port, so the longest walks are those over a list of about CAPACITY entries.
// The block works on one request at a time; busy is high from the accepting edge
// until the result is shown, and a new request may be accepted in the done cycle.
// Reset empties the list at once; the RAM contents are not cleared, as no entry at
// or past the length is ever read.
module sequential_list_engine_unit #(
	parameter int unsigned CAPACITY = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic        [slen_pkg::FUNC_W-1:0]     func,
	input  wire logic        [slen_pkg::POS_W-1:0]      position,
	input  wire logic signed [slen_pkg::VAL_W-1:0]      value,
	output logic                                        done,
	output logic             [slen_pkg::STATUS_W-1:0]   status,
	output logic signed      [slen_pkg::VAL_W-1:0]      read_value,
	output logic             [slen_pkg::POS_W-1:0]      found_index,
	output logic             [slen_pkg::LEN_W-1:0]      length
);

	// Address width of the RAM, and width of a count that can hold CAPACITY itself.
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	// Width in which a requested position is compared with the length.
	localparam int unsigned CW = (LW > slen_pkg::POS_W) ? LW : slen_pkg::POS_W;
	localparam int unsigned VW = slen_pkg::VAL_W;

	slen_pkg::state_t state_q, state_d;

	slen_pkg::func_t  req_func_q;
	logic [CW-1:0]    req_pos_q;
	logic [VW-1:0]    req_val_q;

	logic [LW-1:0]    len_q, len_d;
	logic [LW-1:0]    ptr_q, ptr_d;

	// Stage one of the walk: a read has been issued, its data arrives this cycle.
	logic             rv_s1, rv_d;
	logic [AW-1:0]    wa_s1, wa_d;
	logic [VW-1:0]    mem_rdata_s1;

	logic             done_q;
	slen_pkg::status_t status_q;
	logic [VW-1:0]    read_value_q;
	logic [AW-1:0]    found_q;

	// RAM controls.
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [VW-1:0]    mem_wd;
	logic             mem_re;
	logic [AW-1:0]    mem_ra;

	logic [VW-1:0]    mem [CAPACITY];

	// Completion of the current request.
	logic              fin;
	slen_pkg::status_t fin_status;
	logic [VW-1:0]     fin_rd;
	logic [AW-1:0]     fin_fidx;
	logic              walk_go;
	logic              more;

	// Widened and narrowed views used for comparisons and ports.
	logic [CW+slen_pkg::POS_W-1:0] pos_wide;
	logic [CW+LW-1:0]              len_wide;
	logic [CW-1:0]                 len_c;
	logic [LW-1:0]                 pos_l;
	logic                          len_full;
	logic [LW+slen_pkg::LEN_W-1:0] len_out_wide;
	logic [AW+slen_pkg::POS_W-1:0] fidx_out_wide;

	assign pos_wide = {{CW{1'b0}}, position};
	assign len_wide = {{CW{1'b0}}, len_q};
	assign len_c    = len_wide[CW-1:0];
	assign pos_l    = req_pos_q[LW-1:0];
	assign len_full = (len_q == LW'(CAPACITY));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slen_pkg::S_IDLE: begin
				if (start) begin
					state_d = slen_pkg::S_EXEC;
				end
			end
			slen_pkg::S_EXEC: begin
				state_d = walk_go ? slen_pkg::S_WALK : slen_pkg::S_IDLE;
			end
			slen_pkg::S_WALK: begin
				if (fin) begin
					state_d = slen_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = slen_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath control: RAM accesses, pointer, length and the result.
	always_comb begin
		mem_we     = 1'b0;
		mem_wa     = wa_s1;
		mem_wd     = mem_rdata_s1;
		mem_re     = 1'b0;
		mem_ra     = ptr_q[AW-1:0];
		ptr_d      = ptr_q;
		wa_d       = wa_s1;
		len_d      = len_q;
		fin        = 1'b0;
		fin_status = slen_pkg::ST_OK;
		fin_rd     = '0;
		fin_fidx   = '0;
		walk_go    = 1'b0;
		more       = 1'b0;

		unique case (state_q)
			slen_pkg::S_EXEC: begin
				case (req_func_q)
					slen_pkg::FN_APPEND: begin
						fin = 1'b1;
						if (len_full) begin
							fin_status = slen_pkg::ST_FULL;
						end else begin
							mem_we = 1'b1;
							mem_wa = len_q[AW-1:0];
							mem_wd = req_val_q;
							len_d  = len_q + 1'b1;
						end
					end
					slen_pkg::FN_INSERT: begin
						if (req_pos_q > len_c) begin
							fin        = 1'b1;
							fin_status = slen_pkg::ST_BAD_POS;
						end else if (len_full) begin
							fin        = 1'b1;
							fin_status = slen_pkg::ST_FULL;
						end else begin
							walk_go = 1'b1;
							ptr_d   = len_q;
						end
					end
					slen_pkg::FN_ERASE: begin
						if (req_pos_q >= len_c) begin
							fin        = 1'b1;
							fin_status = slen_pkg::ST_BAD_POS;
						end else begin
							walk_go = 1'b1;
							ptr_d   = pos_l + 1'b1;
						end
					end
					slen_pkg::FN_FIND: begin
						walk_go = 1'b1;
						ptr_d   = '0;
					end
					slen_pkg::FN_READ: begin
						if (req_pos_q >= len_c) begin
							fin        = 1'b1;
							fin_status = slen_pkg::ST_BAD_POS;
						end else begin
							walk_go = 1'b1;
							mem_re  = 1'b1;
							mem_ra  = req_pos_q[AW-1:0];
						end
					end
					slen_pkg::FN_WRITE: begin
						fin = 1'b1;
						if (req_pos_q >= len_c) begin
							fin_status = slen_pkg::ST_BAD_POS;
						end else begin
							mem_we = 1'b1;
							mem_wa = req_pos_q[AW-1:0];
							mem_wd = req_val_q;
						end
					end
					slen_pkg::FN_CLEAR: begin
						fin   = 1'b1;
						len_d = '0;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			slen_pkg::S_WALK: begin
				case (req_func_q)
					slen_pkg::FN_INSERT: begin
						more = (ptr_q > pos_l);
						// Move the element read last cycle one place up.
						if (rv_s1) begin
							mem_we = 1'b1;
						end
						if (more) begin
							mem_re = 1'b1;
							mem_ra = AW'(ptr_q - 1'b1);
							wa_d   = ptr_q[AW-1:0];
							ptr_d  = ptr_q - 1'b1;
						end else if (!rv_s1) begin
							fin    = 1'b1;
							mem_we = 1'b1;
							mem_wa = req_pos_q[AW-1:0];
							mem_wd = req_val_q;
							len_d  = len_q + 1'b1;
						end
					end
					slen_pkg::FN_ERASE: begin
						more = (ptr_q < len_q);
						// Move the element read last cycle one place down.
						if (rv_s1) begin
							mem_we = 1'b1;
						end
						if (more) begin
							mem_re = 1'b1;
							mem_ra = ptr_q[AW-1:0];
							wa_d   = AW'(ptr_q - 1'b1);
							ptr_d  = ptr_q + 1'b1;
						end else if (!rv_s1) begin
							fin   = 1'b1;
							len_d = len_q - 1'b1;
						end
					end
					slen_pkg::FN_FIND: begin
						more = (ptr_q < len_q);
						if (more) begin
							mem_re = 1'b1;
							mem_ra = ptr_q[AW-1:0];
							wa_d   = ptr_q[AW-1:0];
							ptr_d  = ptr_q + 1'b1;
						end
						if (rv_s1 && (mem_rdata_s1 == req_val_q)) begin
							fin      = 1'b1;
							fin_fidx = wa_s1;
						end else if (!more && !rv_s1) begin
							fin        = 1'b1;
							fin_status = slen_pkg::ST_NOT_FOUND;
						end
					end
					slen_pkg::FN_READ: begin
						if (rv_s1) begin
							fin    = 1'b1;
							fin_rd = mem_rdata_s1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase

		// A read still in flight when the request ends is simply dropped.
		rv_d = mem_re && !fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slen_pkg::S_IDLE;
			len_q   <= '0;
			rv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			rv_s1   <= rv_d;
			done_q  <= fin;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == slen_pkg::S_IDLE) && start) begin
			req_func_q <= slen_pkg::func_t'(func);
			req_pos_q  <= pos_wide[CW-1:0];
			req_val_q  <= value;
		end
		ptr_q <= ptr_d;
		wa_s1 <= wa_d;
		if (fin) begin
			status_q     <= fin_status;
			read_value_q <= fin_rd;
			found_q      <= fin_fidx;
		end
	end

	// Element RAM: one write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rdata_s1 <= mem[mem_ra];
		end
	end

	assign len_out_wide  = {{slen_pkg::LEN_W{1'b0}}, len_q};
	assign fidx_out_wide = {{slen_pkg::POS_W{1'b0}}, found_q};

	assign busy        = (state_q != slen_pkg::S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign found_index = fidx_out_wide[slen_pkg::POS_W-1:0];
	assign length      = len_out_wide[slen_pkg::LEN_W-1:0];

endmodule

`default_nettype wire

### bench/list_result_checker.sv
`timescale 1ns / 1ps

module list_result_checker #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic        [slen_pkg::FUNC_W-1:0]   func,
	input  logic        [slen_pkg::POS_W-1:0]    position,
	input  logic signed [slen_pkg::VAL_W-1:0]    value,
	input  logic                                 done,
	input  logic        [slen_pkg::STATUS_W-1:0] status,
	input  logic signed [slen_pkg::VAL_W-1:0]    read_value,
	input  logic        [slen_pkg::POS_W-1:0]    found_index,
	input  logic        [slen_pkg::LEN_W-1:0]    length,
	output int unsigned                          mismatches,
	output int unsigned                          pending,
	output logic        [slen_pkg::LEN_W-1:0]    list_len
);

	typedef struct packed {
		slen_pkg::status_t                 st;
		logic signed [slen_pkg::VAL_W-1:0] rd;
		logic [slen_pkg::POS_W-1:0]        idx;
		logic [slen_pkg::LEN_W-1:0]        len;
	} list_answer_t;

	logic signed [slen_pkg::VAL_W-1:0] elements [CAPACITY];
	int                                count_q = 0;
	int unsigned                       fails = 0;
	list_answer_t                      awaited [$];

	// Carries out one request on the shadow list and returns the answer it must produce.
	function automatic list_answer_t apply_request(input logic [slen_pkg::FUNC_W-1:0] f,
			input logic [slen_pkg::POS_W-1:0] pos,
			input logic signed [slen_pkg::VAL_W-1:0] v);
		list_answer_t a;
		int           p;
		a = '0;
		p = pos;
		case (f)
			slen_pkg::FN_APPEND: begin
				if (count_q >= CAPACITY) begin
					a.st = slen_pkg::ST_FULL;
				end else begin
					elements[count_q] = v;
					count_q++;
				end
			end
			slen_pkg::FN_INSERT: begin
				if (p > count_q) begin
					a.st = slen_pkg::ST_BAD_POS;
				end else if (count_q >= CAPACITY) begin
					a.st = slen_pkg::ST_FULL;
				end else begin
					for (int i = count_q; i > p; i--)
						elements[i] = elements[i-1];
					elements[p] = v;
					count_q++;
				end
			end
			slen_pkg::FN_ERASE: begin
				if (p >= count_q) begin
					a.st = slen_pkg::ST_BAD_POS;
				end else begin
					for (int i = p; i + 1 < count_q; i++)
						elements[i] = elements[i+1];
					count_q--;
				end
			end
			slen_pkg::FN_FIND: begin
				a.st = slen_pkg::ST_NOT_FOUND;
				for (int i = 0; i < count_q && a.st == slen_pkg::ST_NOT_FOUND; i++) begin
					if (elements[i] == v) begin
						a.st  = slen_pkg::ST_OK;
						a.idx = i[slen_pkg::POS_W-1:0];
					end
				end
			end
			slen_pkg::FN_READ: begin
				if (p >= count_q)
					a.st = slen_pkg::ST_BAD_POS;
				else
					a.rd = elements[p];
			end
			slen_pkg::FN_WRITE: begin
				if (p >= count_q)
					a.st = slen_pkg::ST_BAD_POS;
				else
					elements[p] = v;
			end
			slen_pkg::FN_CLEAR: begin
				count_q = 0;
			end
			default: begin
			end
		endcase
		a.len = count_q[slen_pkg::LEN_W-1:0];
		return a;
	endfunction

	// Results are checked before new requests are predicted, as a request may be taken
	// in the very cycle that the previous result is shown.
	always @(posedge clk) begin : watch
		list_answer_t got;
		list_answer_t want;
		if (arst_n) begin
			if (done) begin
				got.st  = slen_pkg::status_t'(status);
				got.rd  = read_value;
				got.idx = found_index;
				got.len = length;
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result: status %0d value %0d index %0d length %0d",
						$time, got.st, got.rd, got.idx, got.len);
					fails++;
				end else begin
					want = awaited.pop_front();
					if (got !== want) begin
						$display("%0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
							$time, want.st, want.rd, want.idx, want.len,
							got.st, got.rd, got.idx, got.len);
						fails++;
					end
				end
			end
			if (start && !busy)
				awaited = {awaited, apply_request(func, position, value)};
		end
		mismatches <= fails;
		pending    <= awaited.size();
		list_len   <= count_q[slen_pkg::LEN_W-1:0];
	end

endmodule

### bench/tb_sequential_list_engine_unit.sv
`timescale 1ns / 1ps

// Stimulus side of the list engine bench. This module only creates request
// transactions and gives the verdict; prediction and comparison live in the checker
// instantiated beside the block.
module tb_sequential_list_engine_unit;

	localparam int unsigned LIST_CAPACITY = 1024;
	localparam int unsigned RANDOM_ITEMS  = 560;
	// The final stretch of random traffic is sent back to back, with no idle cycles.
	localparam int unsigned QUIET_TAIL    = 60;
	localparam int unsigned POS_MAX       = (1 << slen_pkg::POS_W) - 1;
	// Code seven has no operation behind it; the block must answer it and change nothing.
	localparam logic [slen_pkg::FUNC_W-1:0] FN_UNUSED = 3'd7;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [slen_pkg::FUNC_W-1:0]       func;
	logic [slen_pkg::POS_W-1:0]        position;
	logic signed [slen_pkg::VAL_W-1:0] value;
	logic                              done;
	logic [slen_pkg::STATUS_W-1:0]     status;
	logic signed [slen_pkg::VAL_W-1:0] read_value;
	logic [slen_pkg::POS_W-1:0]        found_index;
	logic [slen_pkg::LEN_W-1:0]        length;

	int unsigned                       mismatches;
	int unsigned                       pending;
	logic [slen_pkg::LEN_W-1:0]        list_len;

	int unsigned                       op_tally [8];
	int unsigned                       peak_len = 0;
	bit                                quiet = 1'b0;

	// A small set of keys that recur often, so that finds hit, duplicates appear and the
	// first-match rule is exercised. The two extremes of the signed range are among them.
	logic signed [slen_pkg::VAL_W-1:0] key_pool [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF,
		32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd42, -32'sd7};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sequential_list_engine_unit #(
		.CAPACITY(LIST_CAPACITY)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.found_index(found_index),
		.length     (length)
	);

	list_result_checker #(
		.CAPACITY(LIST_CAPACITY)
	) answer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.found_index(found_index),
		.length     (length),
		.mismatches (mismatches),
		.pending    (pending),
		.list_len   (list_len)
	);

	// Holds start low for the given number of cycles. The request fields carry random
	// rubbish meanwhile, which the block must ignore.
	task automatic sender_gap(input int unsigned cycles);
		logic [31:0] noise_f;
		logic [31:0] noise_p;
		for (int n = 0; n < cycles; n++) begin
			noise_f = $urandom;
			noise_p = $urandom;
			start    <= 1'b0;
			func     <= noise_f[slen_pkg::FUNC_W-1:0];
			position <= noise_p[slen_pkg::POS_W-1:0];
			value    <= $urandom;
			@(posedge clk);
		end
	endtask

	// Presents one request transaction and returns at the edge that takes it. Start is
	// left high, so a following call keeps the channel busy without a bubble; otherwise
	// a random burst of idle cycles may follow, which lands on whatever phase the block
	// happens to be in.
	task automatic send_request(input logic [slen_pkg::FUNC_W-1:0] f,
			input logic [slen_pkg::POS_W-1:0] pos,
			input logic signed [slen_pkg::VAL_W-1:0] v);
		start    <= 1'b1;
		func     <= f;
		position <= pos;
		value    <= v;
		do
			@(posedge clk);
		while (busy);
		op_tally[f]++;
		if (list_len > peak_len)
			peak_len = list_len;
		if (!quiet && $urandom_range(0, 3) == 0)
			sender_gap($urandom_range(1, 5));
	endtask

	// Lowers start and waits until every predicted result has come back. The first edge
	// lets the checker register a request taken at the current edge.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [slen_pkg::VAL_W-1:0] pick_value();
		if ($urandom_range(0, 1) == 0)
			return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// One random request. Growth is favoured until the list reaches the ceiling given,
	// after which appends and inserts become erases. Most positions fall within or just
	// past the list; a tenth span the whole position field, so every bit of it toggles.
	task automatic random_request(input int unsigned cap);
		int unsigned                 r;
		int unsigned                 len;
		int unsigned                 reach;
		logic [31:0]                 draw;
		logic [slen_pkg::FUNC_W-1:0] f;
		logic [slen_pkg::POS_W-1:0]  pos;
		len = list_len;
		r = $urandom_range(0, 99);
		if (r < 22)
			f = slen_pkg::FN_APPEND;
		else if (r < 42)
			f = slen_pkg::FN_INSERT;
		else if (r < 54)
			f = slen_pkg::FN_ERASE;
		else if (r < 69)
			f = slen_pkg::FN_FIND;
		else if (r < 84)
			f = slen_pkg::FN_READ;
		else if (r < 95)
			f = slen_pkg::FN_WRITE;
		else if (r < 97)
			f = slen_pkg::FN_CLEAR;
		else
			f = FN_UNUSED;
		if (len >= cap && (f == slen_pkg::FN_APPEND || f == slen_pkg::FN_INSERT))
			f = slen_pkg::FN_ERASE;
		reach = (len > POS_MAX) ? POS_MAX : len;
		r = $urandom_range(0, 9);
		if (r < 7)
			draw = $urandom_range(0, reach);
		else if (r < 9)
			draw = $urandom_range(0, (reach + 3 > POS_MAX) ? POS_MAX : reach + 3);
		else
			draw = $urandom;
		pos = draw[slen_pkg::POS_W-1:0];
		send_request(f, pos, pick_value());
	endtask

	initial begin
		int unsigned random_sent;
		int unsigned cap;
		int unsigned span;
		random_sent = 0;

		arst_n   <= 1'b0;
		start    <= 1'b0;
		func     <= '0;
		position <= '0;
		value    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. On the empty list every positional request is out of range
		// and a find has nothing to match.
		send_request(slen_pkg::FN_READ, 10'd0, 32'sd0);
		send_request(slen_pkg::FN_ERASE, 10'd0, 32'sd0);
		send_request(slen_pkg::FN_WRITE, 10'd0, 32'sd9);
		send_request(slen_pkg::FN_FIND, 10'd0, 32'sd0);
		// An insert beyond the end is refused, one at the end is taken.
		send_request(slen_pkg::FN_INSERT, 10'd1, 32'sd3);
		send_request(slen_pkg::FN_INSERT, 10'd0, 32'sh8000_0000);
		send_request(slen_pkg::FN_APPEND, 10'd1023, 32'sh7FFF_FFFF);
		send_request(slen_pkg::FN_APPEND, 10'd0, 32'sd0);
		send_request(slen_pkg::FN_APPEND, 10'd0, -32'sd1);
		// Insert at a position equal to the length behaves as an append; an insert near
		// the front shifts the tail up and leaves a duplicate key ahead of the other.
		send_request(slen_pkg::FN_INSERT, 10'd4, 32'sd5);
		send_request(slen_pkg::FN_INSERT, 10'd1, 32'sd5);
		send_request(slen_pkg::FN_FIND, 10'd0, 32'sd5);
		send_request(slen_pkg::FN_FIND, 10'd0, -32'sd1);
		// Reads at the last entry and one past it.
		send_request(slen_pkg::FN_READ, 10'd5, 32'sd0);
		send_request(slen_pkg::FN_READ, 10'd6, 32'sd0);
		send_request(slen_pkg::FN_WRITE, 10'd5, 32'sh0000_FFFF);
		// Erase at the front, at the back and in the middle.
		send_request(slen_pkg::FN_ERASE, 10'd0, 32'sd0);
		send_request(slen_pkg::FN_ERASE, 10'd4, 32'sd0);
		send_request(slen_pkg::FN_ERASE, 10'd1, 32'sd0);
		send_request(slen_pkg::FN_READ, 10'd1023, 32'sd0);
		send_request(FN_UNUSED, 10'd1023, 32'sh7FFF_FFFF);
		// Clear empties the list but leaves the store alone: the old keys must no longer
		// be visible to reads or finds.
		send_request(slen_pkg::FN_CLEAR, 10'd0, 32'sd0);
		send_request(slen_pkg::FN_READ, 10'd0, 32'sd0);
		send_request(slen_pkg::FN_FIND, 10'd0, 32'sd5);
		drain_results();

		// Random traffic in episodes, each with its own ceiling on the list length. Most
		// ceilings are small so that walks stay short; now and then a longer list is
		// allowed to build up over several episodes.
		while (random_sent < RANDOM_ITEMS) begin
			cap  = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 300) :
				$urandom_range(2, 40);
			span = $urandom_range(15, 45);
			for (int k = 0; k < span && random_sent < RANDOM_ITEMS; k++) begin
				quiet = (random_sent + QUIET_TAIL >= RANDOM_ITEMS);
				random_request(cap);
				random_sent++;
			end
			// Sometimes the sender stops until the block has answered everything.
			if ($urandom_range(0, 2) == 0 && random_sent + QUIET_TAIL < RANDOM_ITEMS)
				drain_results();
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Requests sent: %0d appends, %0d inserts, %0d erases, %0d finds, %0d reads,",
			op_tally[slen_pkg::FN_APPEND], op_tally[slen_pkg::FN_INSERT],
			op_tally[slen_pkg::FN_ERASE], op_tally[slen_pkg::FN_FIND],
			op_tally[slen_pkg::FN_READ]);
		$display("%0d writes, %0d clears, %0d unused codes; longest list %0d of %0d entries.",
			op_tally[slen_pkg::FN_WRITE], op_tally[slen_pkg::FN_CLEAR], op_tally[FN_UNUSED],
			peak_len, LIST_CAPACITY);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog, set many times above the slowest legal run: every request walking the
	// whole list with the longest idle gap after it.
	initial begin
		#100_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
rtl/core/slen_pkg.sv
rtl/core/sequential_list_engine_unit.sv
bench/list_result_checker.sv
bench/tb_sequential_list_engine_unit.sv
